// ===== design/assert_macros.svh =====
// Assertion macros used by the watchdog supervisor top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MTWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watchdog supervisor check failed");

// Next-cycle implication, checked outside reset
`define MTWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watchdog supervisor check failed");

`endif

// ===== design/mtws_pkg.sv =====
// Shared types and constants for the multi-task watchdog supervisor
package mtws_pkg;

  localparam int ACT_W    = 3;
  localparam int KEY_W    = 32;
  localparam int PERIOD_W = 16;

  localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REGISTER   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEREGISTER = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FEED       = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SLEEP      = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [PERIOD_W-1:0] countdown;
    logic [PERIOD_W-1:0] reload;
    logic                asleep;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== design/mtws_ctrl.sv =====
// Controller state machine: accept, table scan, update, result handoff
module mtws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtws_pkg::sts_t sts,
  output mtws_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/mtws_datapath.sv =====
// Datapath: task table memory, valid bits, scan pipeline and result register
module mtws_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mtws_pkg::cmd_t                 cmd,
  output mtws_pkg::sts_t                 sts,
  input  logic [mtws_pkg::ACT_W-1:0]     in_action,
  input  logic [mtws_pkg::KEY_W-1:0]     in_task_key,
  input  logic [mtws_pkg::PERIOD_W-1:0]  in_period_ticks,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_status,
  output logic                           out_refresh
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  mtws_pkg::entry_t mem [MAX_ENTRIES];
  mtws_pkg::entry_t rd_q_r;

  logic [MAX_ENTRIES-1:0]          valid_r;
  logic [mtws_pkg::ACT_W-1:0]      act_r;
  logic [mtws_pkg::KEY_W-1:0]      key_r;
  logic [mtws_pkg::PERIOD_W-1:0]   period_r;
  logic [CW-1:0]                   idx_r;
  logic                            rd_vld_r;
  logic [AW-1:0]                   rd_idx_r;
  logic                            hit_r;
  logic [AW-1:0]                   hit_idx_r;
  mtws_pkg::entry_t                hit_word_r;
  logic                            free_r;
  logic [AW-1:0]                   free_idx_r;
  logic                            refresh_r;
  logic                            out_valid_r;
  logic                            out_status_r;
  logic                            out_refresh_r;

  logic                            rd_en;
  logic                            cur_valid;
  logic                            cur_awake;
  logic [mtws_pkg::PERIOD_W-1:0]   cd_new;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  mtws_pkg::entry_t                wr_data;
  logic                            vset;
  logic                            vclr;
  logic [AW-1:0]                   slot;
  logic                            reg_ok;
  logic                            res_status;
  logic                            res_refresh;

  assign rd_en     = cmd.scan && (idx_r < CW'(MAX_ENTRIES));
  assign cur_valid = valid_r[rd_idx_r];
  assign cur_awake = cur_valid && !rd_q_r.asleep;
  assign cd_new    = (rd_q_r.countdown != '0) ? (rd_q_r.countdown - 1'b1) : '0;
  assign slot      = hit_r ? hit_idx_r : free_idx_r;
  assign reg_ok    = hit_r || free_r;

  assign sts.scan_done = (idx_r == CW'(MAX_ENTRIES)) && !rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = rd_q_r;
    vset    = 1'b0;
    vclr    = 1'b0;
    if (rd_vld_r && (act_r == mtws_pkg::ACT_TICK) && cur_awake) begin
      wr_en             = 1'b1;
      wr_data.countdown = cd_new;
    end
    if (cmd.apply) begin
      wr_addr = slot;
      wr_data = hit_word_r;
      unique case (act_r)
        mtws_pkg::ACT_REGISTER: begin
          wr_en             = reg_ok;
          vset              = reg_ok;
          wr_data.key       = key_r;
          wr_data.countdown = period_r;
          wr_data.reload    = period_r;
          wr_data.asleep    = 1'b1;
        end
        mtws_pkg::ACT_DEREGISTER: begin
          vclr = hit_r;
        end
        mtws_pkg::ACT_FEED: begin
          wr_en             = hit_r;
          wr_data.asleep    = 1'b0;
          wr_data.countdown = hit_word_r.reload;
        end
        mtws_pkg::ACT_SLEEP: begin
          wr_en          = hit_r;
          wr_data.asleep = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res_refresh = 1'b0;
    unique case (act_r)
      mtws_pkg::ACT_TICK: begin
        res_status  = 1'b0;
        res_refresh = refresh_r;
      end
      mtws_pkg::ACT_REGISTER:   res_status = !reg_ok;
      mtws_pkg::ACT_DEREGISTER: res_status = !hit_r;
      mtws_pkg::ACT_FEED:       res_status = !hit_r;
      mtws_pkg::ACT_SLEEP:      res_status = !hit_r;
      default:                  res_status = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      key_r     <= in_task_key;
      period_r  <= in_period_ticks;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      refresh_r <= 1'b1;
    end else begin
      if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (act_r == mtws_pkg::ACT_TICK) begin
          if (cur_awake && (cd_new == '0)) begin
            refresh_r <= 1'b0;
          end
        end else begin
          if (cur_valid && (rd_q_r.key == key_r) && !hit_r) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= rd_idx_r;
            hit_word_r <= rd_q_r;
          end
          if (!cur_valid && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= rd_idx_r;
          end
        end
      end
    end
    if (rd_en) begin
      rd_idx_r <= idx_r[AW-1:0];
    end
    if (cmd.emit) begin
      out_status_r  <= res_status;
      out_refresh_r <= res_refresh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (vset) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (vclr) begin
        valid_r[wr_addr] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_refresh = out_refresh_r;

endmodule

// ===== design/multi_task_watchdog_supervisor.sv =====
// Top level of the multi-task watchdog supervisor.
// Each item (tick, register, deregister, feed or sleep) walks the whole task
// table once through a single-port read of the entry memory, one entry per
// cycle, and in_tready stays low from transfer in until the walk, the update
// and the handoff into the output register are done; the result waits there, and
// a new item is taken while that result is still unclaimed. Valid bits live
// in flops cleared by reset, so no clearing pass is needed after reset.
`include "assert_macros.svh"

module multi_task_watchdog_supervisor #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // action[2:0], task_key[34:3], period_ticks[50:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[0], refresh[1]
);

  mtws_pkg::cmd_t cmd;
  mtws_pkg::sts_t sts;
  logic           out_status;
  logic           out_refresh;

  mtws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtws_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_tdata[2:0]),
    .in_task_key     (in_tdata[34:3]),
    .in_period_ticks (in_tdata[50:35]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (out_status),
    .out_refresh     (out_refresh)
  );

  assign out_tdata = {6'b0, out_refresh, out_status};

  `MTWS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `MTWS_ASSERT_NOW(a_emit_into_free_slot, cmd.emit, !out_tvalid || out_tready)
  `MTWS_ASSERT_NOW(a_fail_has_no_refresh, out_tvalid && out_tdata[0], !out_tdata[1])

endmodule

// ===== dv/tb_multi_task_watchdog_supervisor.sv =====
// Self-checking testbench for the multi-task watchdog supervisor stream block
`timescale 1ns / 1ps

module tb_multi_task_watchdog_supervisor;

  localparam int TABLE_DEPTH = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam logic [mtws_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [mtws_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [mtws_pkg::ACT_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic status;
    logic refresh;
  } wd_result_t;

  typedef enum int {SINK_READY, SINK_COIN, SINK_PATTERN, SINK_SLOW} sink_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  mtws_pkg::entry_t shadow_entry [TABLE_DEPTH];
  logic             shadow_live  [TABLE_DEPTH];
  logic [mtws_pkg::KEY_W-1:0] key_pool [24];

  wd_result_t  pending_results [$];
  int          error_count;
  int          burst_left;
  int          idle_cycles;
  int          hold_off_len;
  int          hold_off_req_id;

  multi_task_watchdog_supervisor #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int find_task(input logic [mtws_pkg::KEY_W-1:0] task_key);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (shadow_live[i] && shadow_entry[i].key == task_key) return i;
    end
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!shadow_live[i]) return i;
    end
    return -1;
  endfunction

  function automatic bit table_has_tasks();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (shadow_live[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [mtws_pkg::KEY_W-1:0] pick_live_key();
    int start;
    int idx;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      idx = (start + i) % TABLE_DEPTH;
      if (shadow_live[idx]) return shadow_entry[idx].key;
    end
    return key_pool[$urandom_range(0, 23)];
  endfunction

  function automatic wd_result_t predict_watchdog(
      input logic [mtws_pkg::ACT_W-1:0]    act,
      input logic [mtws_pkg::KEY_W-1:0]    task_key,
      input logic [mtws_pkg::PERIOD_W-1:0] period);
    wd_result_t res;
    int slot;
    res = '0;
    slot = find_task(task_key);
    case (act)
      mtws_pkg::ACT_TICK: begin
        res.refresh = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (shadow_live[i] && !shadow_entry[i].asleep) begin
            if (shadow_entry[i].countdown != '0)
              shadow_entry[i].countdown = shadow_entry[i].countdown - 1'b1;
            if (shadow_entry[i].countdown == '0) res.refresh = 1'b0;
          end
        end
      end
      mtws_pkg::ACT_REGISTER: begin
        if (slot < 0) slot = first_free_slot();
        if (slot < 0) begin
          res.status = 1'b1;
        end else begin
          shadow_live[slot]            = 1'b1;
          shadow_entry[slot].key       = task_key;
          shadow_entry[slot].countdown = period;
          shadow_entry[slot].reload    = period;
          shadow_entry[slot].asleep    = 1'b1;
        end
      end
      mtws_pkg::ACT_DEREGISTER: begin
        if (slot < 0) res.status = 1'b1;
        else shadow_live[slot] = 1'b0;
      end
      mtws_pkg::ACT_FEED: begin
        if (slot < 0) begin
          res.status = 1'b1;
        end else begin
          shadow_entry[slot].asleep    = 1'b0;
          shadow_entry[slot].countdown = shadow_entry[slot].reload;
        end
      end
      mtws_pkg::ACT_SLEEP: begin
        if (slot < 0) res.status = 1'b1;
        else shadow_entry[slot].asleep = 1'b1;
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  task automatic send_item(input logic [mtws_pkg::ACT_W-1:0] act,
                           input logic [mtws_pkg::KEY_W-1:0] task_key,
                           input logic [mtws_pkg::PERIOD_W-1:0] period);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, period, task_key, act};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_watchdog(act, task_key, period));
  endtask

  task automatic test_command_basics();
    send_item(mtws_pkg::ACT_TICK, '0, '0);
    send_item(mtws_pkg::ACT_REGISTER, 32'h0000_0000, 16'h0000);
    send_item(mtws_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(mtws_pkg::ACT_TICK, '0, '0);
    // zero period: feed wakes it already expired
    send_item(mtws_pkg::ACT_FEED, 32'h0000_0000, '0);
    send_item(mtws_pkg::ACT_TICK, '1, '1);
    send_item(mtws_pkg::ACT_SLEEP, 32'h0000_0000, '0);
    send_item(mtws_pkg::ACT_SLEEP, 32'h0000_0000, '0);
    send_item(mtws_pkg::ACT_FEED, 32'hFFFF_FFFF, '0);
    send_item(mtws_pkg::ACT_TICK, '0, '0);
    send_item(mtws_pkg::ACT_DEREGISTER, 32'h0000_0000, '0);
    send_item(mtws_pkg::ACT_DEREGISTER, 32'h0000_0000, '0);
    send_item(mtws_pkg::ACT_FEED, 32'h1234_5678, '0);
    send_item(mtws_pkg::ACT_SLEEP, 32'hDEAD_BEEF, '0);
    send_item(mtws_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 16'h0003);
    send_item(mtws_pkg::ACT_FEED, 32'hFFFF_FFFF, '1);
    send_item(mtws_pkg::ACT_TICK, '0, '0);
  endtask

  task automatic test_spare_actions();
    send_item(ACT_SPARE_A, '1, '1);
    send_item(ACT_SPARE_B, 32'hFFFF_FFFF, '0);
    send_item(ACT_SPARE_C, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(mtws_pkg::ACT_TICK, '0, '0);
  endtask

  task automatic test_table_full();
    logic [mtws_pkg::KEY_W-1:0] k;
    while (first_free_slot() >= 0) begin
      do k = $urandom; while (find_task(k) >= 0);
      send_item(mtws_pkg::ACT_REGISTER, k, mtws_pkg::PERIOD_W'($urandom_range(0, 20)));
    end
    do k = $urandom; while (find_task(k) >= 0);
    send_item(mtws_pkg::ACT_REGISTER, k, mtws_pkg::PERIOD_W'($urandom));
    send_item(mtws_pkg::ACT_REGISTER, pick_live_key(),
              mtws_pkg::PERIOD_W'($urandom_range(1, 8)));
    repeat (6) send_item(mtws_pkg::ACT_FEED, pick_live_key(), mtws_pkg::PERIOD_W'($urandom));
    repeat (8) send_item(mtws_pkg::ACT_TICK, mtws_pkg::KEY_W'($urandom),
                         mtws_pkg::PERIOD_W'($urandom));
    send_item(mtws_pkg::ACT_FEED, k, '0);
    // drain the table again
    while (table_has_tasks()) begin
      send_item(mtws_pkg::ACT_DEREGISTER, pick_live_key(), mtws_pkg::PERIOD_W'($urandom));
    end
  endtask

  task automatic random_item();
    logic [mtws_pkg::ACT_W-1:0]    act;
    logic [mtws_pkg::KEY_W-1:0]    k;
    logic [mtws_pkg::PERIOD_W-1:0] period;
    int roll;
    roll = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) < 8) ? pick_live_key() : key_pool[$urandom_range(0, 23)];
    case ($urandom_range(0, 9))
      0:       period = mtws_pkg::PERIOD_W'($urandom);
      1, 2:    period = mtws_pkg::PERIOD_W'($urandom_range(13, 200));
      default: period = mtws_pkg::PERIOD_W'($urandom_range(0, 12));
    endcase
    if (roll < 38) begin
      act = mtws_pkg::ACT_TICK;
      k = $urandom;
    end else if (roll < 54) begin
      act = mtws_pkg::ACT_REGISTER;
      k = key_pool[$urandom_range(0, 23)];
    end else if (roll < 74) begin
      act = mtws_pkg::ACT_FEED;
    end else if (roll < 82) begin
      act = mtws_pkg::ACT_SLEEP;
    end else if (roll < 92) begin
      act = mtws_pkg::ACT_DEREGISTER;
    end else if (roll < 97) begin
      case ($urandom_range(0, 2))
        0:       act = mtws_pkg::ACT_FEED;
        1:       act = mtws_pkg::ACT_SLEEP;
        default: act = mtws_pkg::ACT_DEREGISTER;
      endcase
      k = $urandom;
    end else begin
      act = ACT_SPARE_A + mtws_pkg::ACT_W'($urandom_range(0, 2));
    end
    send_item(act, k, period);
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < 22; i++) key_pool[i] = $urandom;
    key_pool[22] = '0;
    key_pool[23] = '1;
    repeat (count) random_item();
  endtask

  task automatic test_backpressure();
    hold_off_len = HOLD_OFF_CYCLES;
    hold_off_req_id++;
    repeat (60) random_item();
  endtask

  initial begin : result_sink
    sink_mode_t  mode;
    int          mode_left;
    int          hold_left;
    int          seen_req;
    logic [15:0] pattern;
    mode      = SINK_READY;
    mode_left = 0;
    hold_left = 0;
    seen_req  = 0;
    pattern   = '1;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (seen_req != hold_off_req_id) begin
        seen_req  = hold_off_req_id;
        hold_left = hold_off_len;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
        pattern   = 16'($urandom);
      end
      mode_left--;
      pattern = {pattern[14:0], pattern[15]};
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          SINK_READY:   out_tready <= 1'b1;
          SINK_COIN:    out_tready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: out_tready <= pattern[0];
          default:      out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    wd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual status=%0b refresh=%0b",
                 $time, out_tdata[0], out_tdata[1]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.status) begin
          $display("%0t: status mismatch, expected %0b, actual %0b",
                   $time, want.status, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[1] !== want.refresh) begin
          $display("%0t: refresh mismatch, expected %0b, actual %0b",
                   $time, want.refresh, out_tdata[1]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    burst_left      = 0;
    hold_off_len    = 0;
    hold_off_req_id = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_live[i]  = 1'b0;
      shadow_entry[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_command_basics();
    test_spare_actions();
    test_random_traffic(700);
    test_table_full();
    test_backpressure();
    test_random_traffic(800);
    test_table_full();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * (TABLE_DEPTH + 5)) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
